FILE: src/bsil_pkg.sv
package bsil_pkg;

    // Fixed field widths of the request and result, and the read bound.
    localparam int NODE_W  = 16;
    localparam int KEY_W   = 31;
    localparam int IDX_W   = 5;
    localparam int OUT_CW  = 6;
    localparam int READ_MAX = 32;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [IDX_W-1:0]  t_idx;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic  insert;
        t_node node;
        t_key  key;
    } t_cell_ctrl;

endpackage

FILE: src/bounded_sorted_insert_list.sv
// Sorted list of up to LIST_SIZE (node id, distance key) pairs, ascending by key.
// A request is taken at a rising edge where start is high and busy is low. The
// command selects insert, read at an index, clear, or no operation.
// An insert lands ahead of every stored entry with an equal or larger key; the
// entries behind it move down one slot and a full list drops its last entry.
// A key that sorts past the end of a full list is refused and the list holds.
// Every request gives exactly one result, shown for one cycle with o_done high,
// in the cycle after the request is taken. The receiver cannot stall the block.
// Every cell compares its key with the new key and shifts from its neighbor
// in the same cycle, so busy stays low and a new request can follow on every
// cycle. Only the first 32 slots can be read.
// Reset sets busy high; it drops at the first clock edge after reset is released, and the list is then empty.
// Position and count come out modulo 64.
module bounded_sorted_insert_list #(
    parameter int LIST_SIZE = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_cmd,
    input  logic [15:0]            i_node_id,
    input  logic [30:0]            i_key_dist,
    input  logic [4:0]             i_read_index,
    output logic                   o_done,
    output logic                   o_accepted,
    output logic [5:0]             o_position,
    output logic [5:0]             o_count,
    output logic [15:0]            o_out_node,
    output logic [30:0]            o_out_dist,
    output logic                   o_out_valid
);

    localparam int CW     = $clog2(LIST_SIZE + 1);
    localparam int WW     = (CW > bsil_pkg::OUT_CW) ? CW : bsil_pkg::OUT_CW;
    localparam int READ_N = (LIST_SIZE < bsil_pkg::READ_MAX) ? LIST_SIZE
                                                             : bsil_pkg::READ_MAX;

    logic                  r_busy;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    logic                  r_accepted;
    logic [CW-1:0]         r_position;
    bsil_pkg::t_node       r_out_node;
    bsil_pkg::t_key        r_out_dist;
    logic                  r_out_valid;

    logic                  take;
    bsil_pkg::t_cmd        cmd;
    bsil_pkg::t_cell_ctrl  ctrl;
    logic                  ins_ok;
    logic [CW-1:0]         ins_pos;
    logic                  rd_valid;
    bsil_pkg::t_node       rd_node;
    bsil_pkg::t_key        rd_key;
    logic [WW-1:0]         cnt_wide;
    logic [WW-1:0]         pos_wide;

    logic [LIST_SIZE-1:0]  in_use;
    logic [LIST_SIZE-1:0]  lt;
    logic [LIST_SIZE-1:0]  prev_lt;
    logic [LIST_SIZE-1:0]  here;
    bsil_pkg::t_node       cell_node [LIST_SIZE];
    bsil_pkg::t_key        cell_key  [LIST_SIZE];

    assign take = start && !busy;
    assign cmd  = bsil_pkg::t_cmd'(i_cmd);
    assign busy = r_busy;

    // Broadcast of the new pair to the cells.
    assign ctrl.insert = take && (cmd == bsil_pkg::CMD_INSERT);
    assign ctrl.node   = i_node_id;
    assign ctrl.key    = i_key_dist;

    // Chain of cells; each one looks at its upstream neighbor.
    for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cell
        assign in_use[g] = (CW'(g) < r_count);
        if (g == 0) begin : g_head
            assign prev_lt[g] = 1'b1;
            bsil_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_in_use    (in_use[g]),
                .i_prev_lt   (prev_lt[g]),
                .i_prev_node (ctrl.node),
                .i_prev_key  (ctrl.key),
                .o_lt        (lt[g]),
                .o_node      (cell_node[g]),
                .o_key       (cell_key[g])
            );
        end else begin : g_body
            assign prev_lt[g] = lt[g-1];
            bsil_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_in_use    (in_use[g]),
                .i_prev_lt   (prev_lt[g]),
                .i_prev_node (cell_node[g-1]),
                .i_prev_key  (cell_key[g-1]),
                .o_lt        (lt[g]),
                .o_node      (cell_node[g]),
                .o_key       (cell_key[g])
            );
        end
        assign here[g] = prev_lt[g] && !lt[g];
    end

    // The insert is refused only when the key is larger than the last entry.
    assign ins_ok = !lt[LIST_SIZE-1];

    // Encode the single slot where the new pair lands.
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < LIST_SIZE; i++) begin
            if (here[i]) begin
                ins_pos = ins_pos | CW'(i);
            end
        end
        if (!ins_ok) begin
            ins_pos = CW'(LIST_SIZE);
        end
    end

    // Read select over the addressable slots.
    always_comb begin
        rd_valid = 1'b0;
        rd_node  = '0;
        rd_key   = '0;
        for (int i = 0; i < READ_N; i++) begin
            if (i_read_index == bsil_pkg::IDX_W'(i) && in_use[i]) begin
                rd_valid = 1'b1;
                rd_node  = cell_node[i];
                rd_key   = cell_key[i];
            end
        end
    end

    // Fill count update.
    always_comb begin
        n_count = r_count;
        if (take) begin
            unique case (cmd)
                bsil_pkg::CMD_INSERT: begin
                    if (ins_ok && (r_count != CW'(LIST_SIZE))) begin
                        n_count = r_count + CW'(1);
                    end
                end
                bsil_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                bsil_pkg::CMD_READ,
                bsil_pkg::CMD_NOP: begin
                    n_count = r_count;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_count <= n_count;
            r_done  <= take;
        end
    end

    // Result registers; unused fields read as zero.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_accepted  <= ctrl.insert && ins_ok;
            r_position  <= ctrl.insert ? ins_pos : '0;
            r_out_valid <= (cmd == bsil_pkg::CMD_READ) && rd_valid;
            r_out_node  <= (cmd == bsil_pkg::CMD_READ) ? rd_node : '0;
            r_out_dist  <= (cmd == bsil_pkg::CMD_READ) ? rd_key : '0;
        end
    end

    assign cnt_wide    = WW'(r_count);
    assign pos_wide    = WW'(r_position);
    assign o_done      = r_done;
    assign o_accepted  = r_accepted;
    assign o_position  = pos_wide[5:0];
    assign o_count     = cnt_wide[5:0];
    assign o_out_node  = r_out_node;
    assign o_out_dist  = r_out_dist;
    assign o_out_valid = r_out_valid;

    // Every taken request gives one result on the next cycle, and no other.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_done)
        else $error("result strobe missing after a request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> !o_done)
        else $error("result strobe without a request");

    // The fill count never passes the list size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_SIZE))
        else $error("fill count above list size");

    // A refused insert can only happen on a full list.
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.insert && !ins_ok) |-> (r_count == CW'(LIST_SIZE)))
        else $error("insert refused while the list has room");

    // An accepted insert grows the count unless the list was full.
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.insert && ins_ok && (r_count != CW'(LIST_SIZE)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the count");

endmodule

FILE: src/bsil_cell.sv
module bsil_cell (
    input  logic                  i_clk,
    input  bsil_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_in_use,
    input  logic                  i_prev_lt,
    input  bsil_pkg::t_node       i_prev_node,
    input  bsil_pkg::t_key        i_prev_key,
    output logic                  o_lt,
    output bsil_pkg::t_node       o_node,
    output bsil_pkg::t_key        o_key
);

    bsil_pkg::t_node r_node;
    bsil_pkg::t_key  r_key;
    bsil_pkg::t_node n_node;
    bsil_pkg::t_key  n_key;

    // The new key stays behind this entry only if it is strictly larger.
    assign o_lt   = i_in_use && (i_ctrl.key > r_key);
    assign o_node = r_node;
    assign o_key  = r_key;

    // Keep the entry, take the new pair, or take the neighbor's entry.
    always_comb begin
        n_node = r_node;
        n_key  = r_key;
        if (i_ctrl.insert && !o_lt) begin
            if (i_prev_lt) begin
                n_node = i_ctrl.node;
                n_key  = i_ctrl.key;
            end else begin
                n_node = i_prev_node;
                n_key  = i_prev_key;
            end
        end
    end

    // Payload storage needs no reset; the fill count guards it.
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_key  <= n_key;
    end

endmodule
